/* sv/ptc_pkg.sv */
// Shared types and constants for the page translation block with clock replacement.
package ptc_pkg;

  localparam int PAGES_DEF      = 256;
  localparam int FRAMES_DEF     = 64;
  localparam int FRAME_BITS_DEF = 8;

  localparam int VA_W = 20;

  localparam logic [3:0] OFFSET_BITS_RST    = 4'd4;
  localparam logic [4:0] VIRT_ADDR_BITS_RST = 5'd12;

  localparam logic REG_OFFSET_BITS    = 1'b0;
  localparam logic REG_VIRT_ADDR_BITS = 1'b1;

  localparam logic REQ_LOAD      = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_HIT     = 2'd0,
    STATUS_FAULT   = 2'd1,
    STATUS_SEGV    = 2'd2,
    STATUS_NOFRAME = 2'd3
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [19:0] virt_addr;
    logic [7:0]  entry_page;
    logic        entry_valid;
    logic        entry_permission;
    logic [7:0]  entry_frame;
    logic        entry_use;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [19:0] phys_addr;
    logic [7:0]  victim_page;
  } resp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_XL,
    S_PG,
    S_HIT,
    S_SWEEP,
    S_EVICT,
    S_FILL,
    S_RESP
  } fsm_t;

endpackage

/* sv/page_translate_clock_replace.sv */
// Top level: page table lookup with clock (second-chance) frame replacement.
// A load reads the page table, then writes the entry back unless its page is out of range.
// A translate reaches the output register from the range check on an out-of-range segfault,
// after the page table read on a permission segfault, no-frame result or hit, after a use
// bit update on a hit in the ring, and on a fault after a slot ring sweep that clears use
// bits, an eviction and a fill. One item is in flight at a time; the sweep sets the fault
// time. After reset a clearing pass zeroes the page table; no item is taken then.
module page_translate_clock_replace #(
  parameter int PAGES      = ptc_pkg::PAGES_DEF,
  parameter int FRAMES     = ptc_pkg::FRAMES_DEF,
  parameter int FRAME_BITS = ptc_pkg::FRAME_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ptc_pkg::req_t req,
  output logic          resp_valid,
  input  logic          resp_ready,
  output ptc_pkg::resp_t resp,
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [4:0]    cfg_data
);

  localparam int PB  = $clog2(PAGES);
  localparam int SB  = FRAMES > 1 ? $clog2(FRAMES) : 1;
  localparam int CB  = $clog2(FRAMES + 1);
  localparam int VAW = ptc_pkg::VA_W;

  typedef struct packed {
    logic                  valid;
    logic                  perm;
    logic [FRAME_BITS-1:0] frame;
    logic [SB-1:0]         slot;
  } pte_t;

  typedef struct packed {
    logic                  used;
    logic [PB-1:0]         page;
    logic [FRAME_BITS-1:0] frame;
  } slot_t;

  ptc_pkg::fsm_t state, state_next;
  ptc_pkg::req_t item;
  logic [PB-1:0] clr_idx, clr_idx_next;
  logic [SB-1:0] hand_cur, hand_cur_next;
  logic          fwd_clear, fwd_clear_next;
  logic [PB-1:0] victim, victim_next;
  logic [FRAME_BITS-1:0] frame_sel, frame_sel_next;
  ptc_pkg::resp_t result, result_next;
  logic [CB-1:0] slot_count, slot_count_next;
  logic [SB-1:0] clock_hand, clock_hand_next;
  logic [3:0]    offset_bits;
  logic [4:0]    virt_addr_bits;
  logic          resp_load;

  logic          pg_we;
  logic [PB-1:0] pg_waddr, pg_raddr;
  pte_t          pg_wdata, pg_rdata;
  logic          sl_we;
  logic [SB-1:0] sl_waddr, sl_raddr;
  slot_t         sl_wdata, sl_rdata;

  logic [VAW-1:0] va, pg_num;
  logic [PB-1:0]  pidx;
  logic [15:0]    ep16, ef16;
  logic [PB-1:0]  ep_idx;
  logic [FRAME_BITS-1:0] ef;
  logic [CB-1:0]  nx_ext;
  logic [SB-1:0]  nx;
  logic [15:0]    victim16;

  function automatic logic [19:0] phys_of(input logic [FRAME_BITS-1:0] fr,
                                          input logic [19:0] addr,
                                          input logic [3:0] ob);
    logic [19:0] f20;
    logic [19:0] mask;
    f20  = 20'(fr);
    mask = (20'd1 << ob) - 20'd1;
    return (f20 << ob) | (addr & mask);
  endfunction

  ptc_ram #(.WIDTH($bits(pte_t)), .DEPTH(PAGES)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .raddr (pg_raddr),
    .rdata (pg_rdata)
  );

  ptc_ram #(.WIDTH($bits(slot_t)), .DEPTH(FRAMES)) u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  assign va       = item.virt_addr;
  assign pg_num   = va >> offset_bits;
  assign pidx     = pg_num[PB-1:0];
  assign ep16     = {8'd0, item.entry_page};
  assign ep_idx   = ep16[PB-1:0];
  assign ef16     = {8'd0, item.entry_frame};
  assign ef       = ef16[FRAME_BITS-1:0];
  assign nx_ext   = CB'(hand_cur) + CB'(1);
  assign nx       = (nx_ext >= slot_count) ? '0 : nx_ext[SB-1:0];
  assign victim16 = 16'(victim);
  assign req_ready = (state == ptc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic append;
    logic use_eff;
    logic [SB-1:0] h0;
    append          = 1'b0;
    use_eff         = 1'b0;
    h0              = '0;
    state_next      = state;
    clr_idx_next    = clr_idx;
    hand_cur_next   = hand_cur;
    fwd_clear_next  = fwd_clear;
    victim_next     = victim;
    frame_sel_next  = frame_sel;
    result_next     = result;
    slot_count_next = slot_count;
    clock_hand_next = clock_hand;
    resp_load       = 1'b0;
    pg_we           = 1'b0;
    pg_waddr        = pidx;
    pg_wdata        = '0;
    pg_raddr        = pidx;
    sl_we           = 1'b0;
    sl_waddr        = hand_cur;
    sl_wdata        = '0;
    sl_raddr        = hand_cur;
    unique case (state)
      ptc_pkg::S_CLEAR: begin
        pg_we        = 1'b1;
        pg_waddr     = clr_idx;
        clr_idx_next = clr_idx + PB'(1);
        if (clr_idx == PB'(PAGES - 1)) begin
          state_next = ptc_pkg::S_IDLE;
        end
      end
      ptc_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = (req.req_type == ptc_pkg::REQ_LOAD) ? ptc_pkg::S_LD_RD
                                                           : ptc_pkg::S_XL;
        end
      end
      ptc_pkg::S_LD_RD: begin
        pg_raddr = ep_idx;
        state_next = (ep16 >= 16'(PAGES)) ? ptc_pkg::S_IDLE : ptc_pkg::S_LD_WR;
      end
      ptc_pkg::S_LD_WR: begin
        append = item.entry_valid && item.entry_permission && (slot_count < CB'(FRAMES));
        pg_we          = 1'b1;
        pg_waddr       = ep_idx;
        pg_wdata.valid = item.entry_valid;
        pg_wdata.perm  = item.entry_permission;
        pg_wdata.frame = ef;
        pg_wdata.slot  = append ? slot_count[SB-1:0] : pg_rdata.slot;
        if (append) begin
          sl_we           = 1'b1;
          sl_waddr        = slot_count[SB-1:0];
          sl_wdata.used   = item.entry_use;
          sl_wdata.page   = ep_idx;
          sl_wdata.frame  = ef;
          slot_count_next = slot_count + CB'(1);
        end
        state_next = ptc_pkg::S_IDLE;
      end
      ptc_pkg::S_XL: begin
        result_next.status      = ptc_pkg::STATUS_SEGV;
        result_next.phys_addr   = '0;
        result_next.victim_page = '0;
        if (((va >> virt_addr_bits) != '0) || (pg_num >= VAW'(PAGES))) begin
          state_next = ptc_pkg::S_RESP;
        end else begin
          state_next = ptc_pkg::S_PG;
        end
      end
      ptc_pkg::S_PG: begin
        if (!pg_rdata.perm) begin
          state_next = ptc_pkg::S_RESP;
        end else if (pg_rdata.valid) begin
          result_next.status    = ptc_pkg::STATUS_HIT;
          result_next.phys_addr = phys_of(pg_rdata.frame, va, offset_bits);
          if (CB'(pg_rdata.slot) < slot_count) begin
            sl_raddr      = pg_rdata.slot;
            hand_cur_next = pg_rdata.slot;
            state_next    = ptc_pkg::S_HIT;
          end else begin
            state_next = ptc_pkg::S_RESP;
          end
        end else if (slot_count == '0) begin
          result_next.status = ptc_pkg::STATUS_NOFRAME;
          state_next         = ptc_pkg::S_RESP;
        end else begin
          h0             = (CB'(clock_hand) >= slot_count) ? '0 : clock_hand;
          sl_raddr       = h0;
          hand_cur_next  = h0;
          fwd_clear_next = 1'b0;
          state_next     = ptc_pkg::S_SWEEP;
        end
      end
      ptc_pkg::S_HIT: begin
        if (sl_rdata.page == pidx) begin
          sl_we          = 1'b1;
          sl_wdata       = sl_rdata;
          sl_wdata.used  = 1'b1;
        end
        state_next = ptc_pkg::S_RESP;
      end
      ptc_pkg::S_SWEEP: begin
        // With a one-slot ring the cleared entry is read back stale, so the clear is forwarded.
        use_eff = sl_rdata.used && !fwd_clear;
        sl_we   = 1'b1;
        if (use_eff) begin
          sl_wdata       = sl_rdata;
          sl_wdata.used  = 1'b0;
          sl_raddr       = nx;
          hand_cur_next  = nx;
          fwd_clear_next = (nx == hand_cur);
        end else begin
          sl_wdata.used           = 1'b1;
          sl_wdata.page           = pidx;
          sl_wdata.frame          = sl_rdata.frame;
          victim_next             = sl_rdata.page;
          frame_sel_next          = sl_rdata.frame;
          clock_hand_next         = nx;
          pg_raddr                = sl_rdata.page;
          result_next.status      = ptc_pkg::STATUS_FAULT;
          result_next.phys_addr   = phys_of(sl_rdata.frame, va, offset_bits);
          state_next              = ptc_pkg::S_EVICT;
        end
      end
      ptc_pkg::S_EVICT: begin
        result_next.victim_page = victim16[7:0];
        pg_we          = 1'b1;
        pg_waddr       = victim;
        pg_wdata       = pg_rdata;
        pg_wdata.valid = 1'b0;
        state_next     = ptc_pkg::S_FILL;
      end
      ptc_pkg::S_FILL: begin
        pg_we          = 1'b1;
        pg_waddr       = pidx;
        pg_wdata.valid = 1'b1;
        pg_wdata.perm  = 1'b1;
        pg_wdata.frame = frame_sel;
        pg_wdata.slot  = hand_cur;
        state_next     = ptc_pkg::S_RESP;
      end
      ptc_pkg::S_RESP: begin
        if (!resp_valid || resp_ready) begin
          resp_load  = 1'b1;
          state_next = ptc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx        <= '0;
      slot_count     <= '0;
      clock_hand     <= '0;
      fwd_clear      <= 1'b0;
      resp_valid     <= 1'b0;
      offset_bits    <= ptc_pkg::OFFSET_BITS_RST;
      virt_addr_bits <= ptc_pkg::VIRT_ADDR_BITS_RST;
    end else begin
      clr_idx    <= clr_idx_next;
      slot_count <= slot_count_next;
      clock_hand <= clock_hand_next;
      fwd_clear  <= fwd_clear_next;
      if (resp_load) begin
        resp_valid <= 1'b1;
      end else if (resp_ready) begin
        resp_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        if (cfg_index == ptc_pkg::REG_OFFSET_BITS) begin
          offset_bits <= cfg_data[3:0];
        end else begin
          virt_addr_bits <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
    hand_cur  <= hand_cur_next;
    victim    <= victim_next;
    frame_sel <= frame_sel_next;
    result    <= result_next;
    if (resp_load) begin
      resp <= result;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= CB'(FRAMES))
    else $error("slot count exceeds the ring size");

  a_hand_in_ring: assert property (@(posedge clk) disable iff (rst)
    (slot_count != '0) |-> (CB'(clock_hand) < slot_count))
    else $error("clock hand outside the ring");

  a_victim_only_fault: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && resp.status != ptc_pkg::STATUS_FAULT) |-> (resp.victim_page == '0))
    else $error("victim page reported without a fault");

  a_no_addr_on_error: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && (resp.status == ptc_pkg::STATUS_SEGV ||
                    resp.status == ptc_pkg::STATUS_NOFRAME)) |-> (resp.phys_addr == '0))
    else $error("physical address on an error beat");

endmodule

/* sv/ptc_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
